// ===== rtl/hpmm_pkg.sv =====
// Package for the fp16 matrix multiply core: opcodes, constants and fp16
// unpacking. No dependencies.
`default_nettype none
package hpmm_pkg;
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
  localparam logic [8:0]  K_RESET   = 9'd256;

  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
    logic signed [9:0] exp;   // unbiased exponent of the leading one
    logic [10:0] man;         // leading one at bit 10
  } hpmm_half_t;

  function automatic hpmm_half_t unpack_half(input logic [15:0] h);
    hpmm_half_t r;
    logic [4:0] ex;
    logic [9:0] m;
    logic [3:0] lz;
    ex = h[14:10];
    m  = h[9:0];
    r.sign    = h[15];
    r.is_nan  = (ex == 5'h1F) && (m != 10'd0);
    r.is_inf  = (ex == 5'h1F) && (m == 10'd0);
    r.is_zero = (ex == 5'd0) && (m == 10'd0);
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && lz == 4'd0 && (m >> (i + 1)) == 10'd0) lz = 4'(10 - i);
    end
    if (ex == 5'd0) begin
      r.man = 11'(m) << lz;
      r.exp = -10'sd14 - 10'(lz);
    end else begin
      r.man = {1'b1, m};
      r.exp = 10'(ex) - 10'sd15;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/half_precision_matrix_multiply_core.sv =====
// fp16 matrix multiply core, fp32 accumulate. Top level with the k_used
// register. Depends on hpmm_pkg, hpmm_seq.
//
// Load requests are taken one per cycle while no compute is in progress and no
// result is waiting. For each of the min(k_used, INNER) terms of a compute, the
// sequencer reads both stores, then starts the shared multiply-add unit and
// waits for the sum, since each addition needs the previous sum.
// A compute with no terms or with indices out of range gives +0.0. Requests are
// held off until the result is taken.
`default_nettype none
module half_precision_matrix_multiply_core
  import hpmm_pkg::*;
#(
  parameter int ROWS  = 256,
  parameter int COLS  = 256,
  parameter int INNER = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  row_index,
  input  wire logic [7:0]  col_index,
  input  wire logic [15:0] element_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_row,
  output logic [7:0]       out_col,
  output logic [31:0]      product_bits
);
  logic [8:0] k_used;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) k_used <= K_RESET;
    else if (cfg_valid) k_used <= cfg_data;
  end

  hpmm_seq #(.ROWS(ROWS), .COLS(COLS), .INNER(INNER)) u_seq (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .row_index(row_index), .col_index(col_index),
    .element_bits(element_bits), .k_used(k_used),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .product_bits(product_bits)
  );
endmodule
`default_nettype wire

// ===== rtl/hpmm_mac.sv =====
// Shared multiply-add unit: exact fp16 x fp16 product added to an fp32
// accumulator with round-to-nearest-even, three registered stages.
// Depends on hpmm_pkg.
`default_nettype none
module hpmm_mac
  import hpmm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        start,
  input  wire logic [15:0] a_bits,
  input  wire logic [15:0] b_bits,
  input  wire logic [31:0] acc_in,
  output logic             done,
  output logic [31:0]      acc_out
);
  // stage 1: product
  logic        s1_v;
  logic        p_sign, p_nan, p_inf, p_zero;
  logic signed [9:0] p_exp;
  logic [21:0] p_man;
  logic [31:0] s1_acc;
  hpmm_half_t ua, ub;
  always_comb begin
    ua = unpack_half(a_bits);
    ub = unpack_half(b_bits);
  end
  always_ff @(posedge clk) begin
    s1_v   <= start;
    s1_acc <= acc_in;
    p_sign <= ua.sign ^ ub.sign;
    p_nan  <= ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) ||
              (ub.is_inf && ua.is_zero);
    p_inf  <= ua.is_inf || ub.is_inf;
    p_zero <= ua.is_zero || ub.is_zero;
    p_exp  <= ua.exp + ub.exp;
    p_man  <= ua.man * ub.man;
  end

  // stage 2: align both operands on a 50-bit frame and add
  logic        a_sign, a_nan, a_inf, a_zero;
  logic signed [9:0] a_exp;
  logic [23:0] a_man;
  logic        s2_v, r_nan, r_inf, r_infsign, r_zero_both, r_zsign;
  logic        r_sub, s_res_sign;
  logic signed [10:0] big_exp;
  logic signed [51:0] sum;
  always_comb begin
    a_sign = s1_acc[31];
    a_nan  = (s1_acc[30:23] == 8'hFF) && (s1_acc[22:0] != 23'd0);
    a_inf  = (s1_acc[30:23] == 8'hFF) && (s1_acc[22:0] == 23'd0);
    a_zero = (s1_acc[30:0] == 31'd0);
    if (s1_acc[30:23] == 8'd0) begin
      a_man = {1'b0, s1_acc[22:0]};
      a_exp = -10'sd126;
    end else begin
      a_man = {1'b1, s1_acc[22:0]};
      a_exp = 10'(s1_acc[30:23]) - 10'sd127;
    end
  end
  // operands as 50-bit magnitudes, bit 49 weighted 2^e_acc or 2^e_prd
  logic [49:0] m_acc, m_prd, m_big, m_sml;
  logic signed [10:0] e_acc, e_prd, e_big;
  logic [10:0] sh;
  logic [49:0] shifted;
  logic        sticky, s_big, s_sml;
  always_comb begin
    m_acc = {a_man, 26'd0};          // lsb weight 2^(a_exp - 49)
    m_prd = {1'b0, p_man, 27'd0};    // lsb weight 2^(p_exp - 47)
    e_acc = 11'(a_exp);              // bit 49 of m_acc -> a_exp
    e_prd = 11'(p_exp) + 11'sd2;     // bit 48 of m_prd -> p_exp+1, so bit 49 -> p_exp+2
    if (a_zero || (!p_zero && e_prd > e_acc)) begin
      m_big = m_prd; m_sml = a_zero ? 50'd0 : m_acc; e_big = e_prd;
      s_big = p_sign; s_sml = a_sign;
      sh = 11'(e_prd - e_acc);
    end else begin
      m_big = m_acc; m_sml = p_zero ? 50'd0 : m_prd; e_big = e_acc;
      s_big = a_sign; s_sml = p_sign;
      sh = 11'(e_acc - e_prd);
    end
    if (a_zero || p_zero) sh = 11'd0;
    if (sh >= 11'd50) begin
      shifted = 50'd0;
      sticky  = (m_sml != 50'd0);
    end else begin
      shifted = m_sml >> sh;
      sticky  = ((m_sml << (11'd50 - sh)) != 50'd0) && (sh != 11'd0);
    end
  end
  always_ff @(posedge clk) begin
    s2_v        <= s1_v;
    r_nan       <= a_nan || p_nan || (a_inf && p_inf && (a_sign != p_sign));
    r_inf       <= a_inf || p_inf;
    r_infsign   <= a_inf ? a_sign : p_sign;
    r_zero_both <= a_zero && p_zero;
    r_zsign     <= a_sign & p_sign;
    big_exp     <= e_big;
    r_sub       <= (s_big != s_sml);
    // sticky as an extra lsb below the frame
    if (s_big == s_sml)
      sum <= $signed({1'b0, m_big, 1'b0}) + $signed({1'b0, shifted, sticky});
    else
      sum <= $signed({1'b0, m_big, 1'b0}) - $signed({1'b0, shifted, sticky});
    s_res_sign <= s_big;
  end

  // stage 3: normalise and round
  logic [51:0] mag;
  logic        neg;
  logic [5:0]  lead;
  logic signed [11:0] r_exp;
  logic [51:0] nrm;
  logic [24:0] rm;
  logic        g, st, inc;
  logic [7:0]  bexp;
  logic [31:0] res;
  int          shd;
  always_comb begin
    // an addition of like signs may carry into bit 51
    neg  = r_sub && sum[51];
    mag  = neg ? 52'(-sum) : 52'(sum);
    lead = 6'd0;
    for (int i = 0; i < 52; i++) if (mag[i]) lead = 6'(i);
    // frame bit 50 has weight 2^big_exp (bit 49 of m plus one for the sticky lsb)
    r_exp = 12'(big_exp) + 12'(lead) - 12'sd50;
    if (r_exp < -12'sd126) shd = int'(-12'sd126 - r_exp);
    else shd = 0;
    // place leading bit at bit 51, then shift right for subnormals
    nrm = mag << (6'd51 - lead);
    st  = 1'b0;
    if (shd > 0) begin
      if (shd > 51) begin st = (nrm != 52'd0); nrm = 52'd0; end
      else begin
        st  = ((nrm << (52 - shd)) != 52'd0);
        nrm = nrm >> shd;
      end
    end
    rm   = {1'b0, nrm[51:28]};
    g    = nrm[27];
    st   = st | (nrm[26:0] != 27'd0);
    inc  = g && (st || rm[0]);
    rm   = rm + 25'(inc);
    res  = 32'd0;
    bexp = 8'd0;
    if (mag == 52'd0) begin
      res = {r_zero_both ? r_zsign : 1'b0, 31'd0};
    end else begin
      if (rm[24]) begin rm = rm >> 1; r_exp = r_exp + 12'sd1; end
      if (shd > 0) begin
        bexp = rm[23] ? 8'd1 : 8'd0;
      end else begin
        bexp = 8'(r_exp + 12'sd127);
      end
      if (shd == 0 && r_exp > 12'sd127) res = {neg ^ s_res_sign, 8'hFF, 23'd0};
      else res = {neg ^ s_res_sign, bexp, rm[22:0]};
    end
    if (r_nan) res = FP32_QNAN;
    else if (r_inf) res = {r_infsign, 8'hFF, 23'd0};
  end
  always_ff @(posedge clk) begin
    done    <= s2_v;
    acc_out <= res;
  end
endmodule
`default_nettype wire

// ===== rtl/hpmm_seq.sv =====
// Sequencer: holds both matrix stores, steps k through the shared
// multiply-add unit and presents one result. Depends on hpmm_pkg, hpmm_mac.
`default_nettype none
module hpmm_seq
  import hpmm_pkg::*;
#(
  parameter int ROWS  = 256,
  parameter int COLS  = 256,
  parameter int INNER = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  row_index,
  input  wire logic [7:0]  col_index,
  input  wire logic [15:0] element_bits,
  input  wire logic [8:0]  k_used,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_row,
  output logic [7:0]       out_col,
  output logic [31:0]      product_bits
);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int KW = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int TW = $clog2(INNER + 1);
  localparam int AAW = (ROWS * INNER > 1) ? $clog2(ROWS * INNER) : 1;
  localparam int BAW = (INNER * COLS > 1) ? $clog2(INNER * COLS) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [15:0] amem [ROWS*INNER];
  logic [15:0] bmem [INNER*COLS];

  logic [2:0]  state;
  logic [TW-1:0] k, terms;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [15:0] a_q, b_q;
  logic [31:0] acc;
  logic        mac_start, mac_done;
  logic [31:0] mac_out;

  logic take;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign take = in_valid && in_ready;

  logic [31:0] row_w, col_w, kcap;
  logic [AAW-1:0] a_wr_addr, a_rd_addr;
  logic [BAW-1:0] b_wr_addr, b_rd_addr;
  always_comb begin
    row_w = 32'(row_index);
    col_w = 32'(col_index);
    kcap  = (32'(k_used) > 32'(INNER)) ? 32'(INNER) : 32'(k_used);
    a_wr_addr = AAW'(row_w * 32'(INNER) + col_w);
    b_wr_addr = BAW'(row_w * 32'(COLS) + col_w);
    a_rd_addr = AAW'(32'(r) * 32'(INNER) + 32'(k[KW-1:0]));
    b_rd_addr = BAW'(32'(k[KW-1:0]) * 32'(COLS) + 32'(c));
  end

  always_ff @(posedge clk) begin
    if (take && opcode == OP_LOAD_A && row_w < 32'(ROWS) && col_w < 32'(INNER))
      amem[a_wr_addr] <= element_bits;
    if (take && opcode == OP_LOAD_B && row_w < 32'(INNER) && col_w < 32'(COLS))
      bmem[b_wr_addr] <= element_bits;
  end

  always_ff @(posedge clk) begin
    a_q <= amem[a_rd_addr];
    b_q <= bmem[b_rd_addr];
  end

  assign mac_start = (state == ST_MAC);

  hpmm_mac u_mac (
    .clk(clk), .start(mac_start), .a_bits(a_q), .b_bits(b_q),
    .acc_in(acc), .done(mac_done), .acc_out(mac_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take && opcode == OP_COMPUTE) begin
            out_row <= row_index;
            out_col <= col_index;
            acc     <= 32'd0;
            k       <= '0;
            terms   <= TW'(kcap);
            r       <= RW'(row_index);
            c       <= CW'(col_index);
            if (row_w >= 32'(ROWS) || col_w >= 32'(COLS) || kcap == 32'd0)
              state <= ST_OUT;
            else
              state <= ST_READ;
          end
        end
        ST_READ: state <= ST_MAC;
        ST_MAC:  state <= ST_WAIT;
        ST_WAIT: begin
          if (mac_done) begin
            acc <= mac_out;
            k   <= k + TW'(1);
            state <= (k + TW'(1) == terms) ? ST_OUT : ST_READ;
          end
        end
        ST_OUT: begin
          product_bits <= acc;
          out_valid    <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/hpmm_checker.sv =====
// Port checker for the fp16 matrix multiply core, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module hpmm_port_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [31:0] product_bits
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product_bits))
    else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request taken with result pending");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind half_precision_matrix_multiply_core hpmm_port_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .product_bits(product_bits)
);
`default_nettype wire

// ===== dv/hpmm_checker.sv =====
// Scoreboard for the fp16 matrix multiply core: mirrors both matrix stores and
// k_used, predicts each dot product and compares every result taken.
// Depends on hpmm_pkg.
`timescale 1ns / 1ps
module hpmm_checker
  import hpmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  row_index,
  input  logic [7:0]  col_index,
  input  logic [15:0] element_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_row,
  input  logic [7:0]  out_col,
  input  logic [31:0] product_bits,
  output int          mismatches,
  output int          pending
);
  typedef logic signed [199:0] fixed_t;
  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] bits;
  } dot_result_t;

  logic [15:0] a_mirror [65536];
  logic [15:0] b_mirror [65536];
  logic [8:0]  k_mirror;
  dot_result_t expected_dots[$];

  assign pending = expected_dots.size();

  // value in units of 2**-48
  function automatic fixed_t single_to_fixed(input logic [31:0] f);
    int     ee;
    int     sh;
    fixed_t mant;
    ee   = (f[30:23] == 8'd0) ? 1 : int'(f[30:23]);
    mant = (f[30:23] == 8'd0) ? fixed_t'(f[22:0]) : fixed_t'({1'b1, f[22:0]});
    sh   = ee - 102;
    mant = (sh >= 0) ? (mant <<< sh) : (mant >>> (-sh));
    return f[31] ? -mant : mant;
  endfunction

  function automatic logic [31:0] fixed_to_single(input fixed_t v);
    logic [199:0] mag;
    logic [24:0]  keep;
    logic         guard;
    logic         sticky;
    int           p;
    int           sh;
    int           ex;
    if (v == 0) return 32'd0;
    mag = (v < 0) ? -v : v;
    p = 0;
    for (int i = 0; i < 200; i++) if (mag[i]) p = i;
    if (p <= 23) begin
      keep = 25'(mag << (23 - p));
    end else begin
      sh     = p - 23;
      keep   = 25'(mag >> sh);
      guard  = mag[sh-1];
      sticky = |(mag & ((200'd1 << (sh - 1)) - 200'd1));
      if (guard && (sticky || keep[0])) keep = keep + 25'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        p++;
      end
    end
    ex = p + 79;
    if (ex >= 255) return {v < 0, 31'h7F80_0000};
    return {v < 0, 8'(ex), keep[22:0]};
  endfunction

  function automatic fixed_t exact_product(input logic [15:0] a, input logic [15:0] b);
    int     ea;
    int     eb;
    fixed_t ma;
    fixed_t mb;
    ma = (a[14:10] == 5'd0) ? fixed_t'(a[9:0]) : fixed_t'({1'b1, a[9:0]});
    mb = (b[14:10] == 5'd0) ? fixed_t'(b[9:0]) : fixed_t'({1'b1, b[9:0]});
    ea = (a[14:10] == 5'd0) ? -24 : int'(a[14:10]) - 25;
    eb = (b[14:10] == 5'd0) ? -24 : int'(b[14:10]) - 25;
    ma = (ma * mb) <<< (ea + eb + 48);
    return (a[15] ^ b[15]) ? -ma : ma;
  endfunction

  function automatic logic [31:0] dot_product(input logic [7:0] r, input logic [7:0] c);
    logic [31:0] acc;
    logic [15:0] a;
    logic [15:0] b;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, acc_nan, acc_inf;
    logic        p_nan, p_inf, p_sign;
    int          terms;
    acc   = 32'd0;
    terms = (k_mirror > 9'd256) ? 256 : int'(k_mirror);
    for (int k = 0; k < terms; k++) begin
      a       = a_mirror[{r, 8'(k)}];
      b       = b_mirror[{8'(k), c}];
      a_nan   = a[14:10] == 5'h1F && a[9:0] != 0;
      b_nan   = b[14:10] == 5'h1F && b[9:0] != 0;
      a_inf   = a[14:10] == 5'h1F && a[9:0] == 0;
      b_inf   = b[14:10] == 5'h1F && b[9:0] == 0;
      a_zero  = a[14:0] == 15'd0;
      b_zero  = b[14:0] == 15'd0;
      p_nan   = a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf);
      p_inf   = a_inf || b_inf;
      p_sign  = a[15] ^ b[15];
      acc_nan = acc[30:23] == 8'hFF && acc[22:0] != 0;
      acc_inf = acc[30:23] == 8'hFF && acc[22:0] == 0;
      if (acc_nan || p_nan) acc = FP32_QNAN;
      else if (acc_inf) begin
        if (p_inf && p_sign != acc[31]) acc = FP32_QNAN;
      end else if (p_inf) acc = {p_sign, 31'h7F80_0000};
      else acc = fixed_to_single(single_to_fixed(acc) + exact_product(a, b));
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    dot_result_t exp_dot;
    if (rst) begin
      k_mirror   = K_RESET;
      mismatches = 0;
      expected_dots.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result row %0d col %0d bits %h", out_row, out_col,
                     product_bits);
        end else begin
          exp_dot = expected_dots.pop_front();
          if (out_row !== exp_dot.row || out_col !== exp_dot.col ||
              product_bits !== exp_dot.bits) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0d %h, got %0d/%0d %h", exp_dot.row,
                       exp_dot.col, exp_dot.bits, out_row, out_col, product_bits);
          end
        end
      end
      if (cfg_valid && cfg_ready) k_mirror = cfg_data;
      if (in_valid && in_ready) begin
        case (opcode)
          OP_LOAD_A:  a_mirror[{row_index, col_index}] = element_bits;
          OP_LOAD_B:  b_mirror[{row_index, col_index}] = element_bits;
          OP_COMPUTE: begin
            exp_dot.row  = row_index;
            exp_dot.col  = col_index;
            exp_dot.bits = dot_product(row_index, col_index);
            expected_dots.push_back(exp_dot);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the fp16 matrix multiply core bench: clock, reset, request and
// k_used stimulus with random back-pressure, and the verdict.
// Depends on hpmm_pkg, half_precision_matrix_multiply_core, hpmm_checker.
`timescale 1ns / 1ps
module testbench;
  import hpmm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [7:0]  row_index = '0;
  logic [7:0]  col_index = '0;
  logic [15:0] element_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic [31:0] product_bits;
  int          mismatches;
  int          pending;

  bit a_written [65536];
  bit b_written [65536];
  int requests_sent = 0;
  int burst_left = 4;
  int stall_mode = 0;
  int stall_left = 0;
  int n_terms;
  int iters;
  int phase = 0;
  int k_schedule [14] = '{1, 3, 2, 256, 5, 16, 511, 0, 4, 8, 7, 255, 1, 6};

  half_precision_matrix_multiply_core i_dut (.*);

  hpmm_checker i_checker (.*);

  initial forever #10 clk = ~clk;

  initial begin
    #(64'd200_000_000);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 200);
      end
      stall_left--;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
                              input logic [15:0] e);
    in_valid     <= 1'b1;
    opcode       <= op;
    row_index    <= r;
    col_index    <= c;
    element_bits <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_LOAD_A) a_written[{r, c}] = 1'b1;
    if (op == OP_LOAD_B) b_written[{r, c}] = 1'b1;
    if (op != OP_UNUSED) requests_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_and_write_k(input logic [8:0] k);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_terms = (k > 9'd256) ? 256 : int'(k);
  endtask

  function automatic logic [15:0] pick_element();
    if ($urandom_range(0, 5) != 0) return 16'($urandom);
    case ($urandom_range(0, 10))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7C00;
      3:       return 16'hFC00;
      4:       return 16'h7E00;
      5:       return 16'h7C01;
      6:       return 16'h0001;
      7:       return 16'h03FF;
      8:       return 16'h7BFF;
      9:       return 16'hFBFF;
      default: return 16'h3C00;
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return 8'd255;
      1, 2:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 5));
    endcase
  endfunction

  task automatic load_and_compute(input logic [7:0] r, input logic [7:0] c);
    for (int k = 0; k < n_terms; k++) begin
      if (!a_written[{r, 8'(k)}] || $urandom_range(0, 15) == 0)
        send_request(OP_LOAD_A, r, 8'(k), pick_element());
      if (!b_written[{8'(k), c}] || $urandom_range(0, 15) == 0)
        send_request(OP_LOAD_B, 8'(k), c, pick_element());
    end
    send_request(OP_COMPUTE, r, c, 16'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drain_and_write_k(9'd2);
    send_request(OP_LOAD_A, 8'd0, 8'd0, 16'h3C00);
    send_request(OP_LOAD_A, 8'd0, 8'd1, 16'hC000);
    send_request(OP_LOAD_B, 8'd0, 8'd0, 16'h4000);
    send_request(OP_LOAD_B, 8'd1, 8'd0, 16'h3C00);
    send_request(OP_COMPUTE, 8'd0, 8'd0, 16'hFFFF);
    send_request(OP_LOAD_A, 8'd255, 8'd0, 16'h7BFF);
    send_request(OP_LOAD_A, 8'd255, 8'd1, 16'h7BFF);
    send_request(OP_LOAD_B, 8'd0, 8'd255, 16'h7BFF);
    send_request(OP_LOAD_B, 8'd1, 8'd255, 16'hFBFF);
    send_request(OP_COMPUTE, 8'd255, 8'd255, 16'h0000);
    send_request(OP_LOAD_A, 8'd1, 8'd0, 16'h7C00);
    send_request(OP_LOAD_A, 8'd1, 8'd1, 16'h0000);
    send_request(OP_COMPUTE, 8'd1, 8'd0, 16'h0000);
    send_request(OP_LOAD_B, 8'd0, 8'd1, 16'h0000);
    send_request(OP_LOAD_B, 8'd1, 8'd1, 16'h0001);
    send_request(OP_COMPUTE, 8'd1, 8'd1, 16'h0000);
    send_request(OP_LOAD_A, 8'd1, 8'd1, 16'hFC00);
    send_request(OP_COMPUTE, 8'd1, 8'd0, 16'h0000);
    send_request(OP_LOAD_A, 8'd2, 8'd0, 16'h0001);
    send_request(OP_LOAD_A, 8'd2, 8'd1, 16'h83FF);
    send_request(OP_COMPUTE, 8'd2, 8'd1, 16'h0000);
    send_request(OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    send_request(OP_LOAD_A, 8'd0, 8'd1, 16'h7E00);
    send_request(OP_COMPUTE, 8'd0, 8'd255, 16'h0000);
    drain_and_write_k(9'd0);
    send_request(OP_COMPUTE, 8'd255, 8'd255, 16'h0000);

    while (requests_sent < 1700) begin
      drain_and_write_k(9'(k_schedule[phase % 14]));
      phase++;
      iters = (n_terms >= 64) ? 3 : 40;
      for (int i = 0; i < iters; i++) begin
        case ($urandom_range(0, 9))
          0, 1:    send_request(2'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                                pick_element());
          2:       send_request(OP_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
          default: load_and_compute(pick_index(), pick_index());
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
